[sv/byte_ring_buffer_fifo_unit_assert.svh]
// ============================================================================
// Assertion macros for the byte ring buffer FIFO
// Concurrent checks on i_clk, quiet while i_rst_n is low; empty in synthesis.
// ============================================================================
`ifndef BYTE_RING_BUFFER_FIFO_UNIT_ASSERT_SVH
`define BYTE_RING_BUFFER_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BRBF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define BRBF_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define BRBF_ASSERT(lbl, expr, msg)
`define BRBF_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

[sv/brbf_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// brbf_pkg
// Beat types, operation codes and fixed widths of the byte ring buffer FIFO.
// ============================================================================
package brbf_pkg;

    localparam int CAP_W  = 13;
    localparam int CNT_W  = 7;
    localparam int FILL_W = 13;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       data_in;
        logic [CNT_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        data_out;
        logic              has_data;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill_level;
        logic              empty_res;
        logic              full_res;
    } t_out_item;

endpackage

[sv/byte_ring_buffer_fifo_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// byte_ring_buffer_fifo_unit
// Circular byte FIFO with a programmable ring size and burst reads.
// ============================================================================
// A write beat stores one byte, a read beat drains up to MAX_BURST bytes in
// order and a flush empties the ring; every result beat reports the fill
// level and the empty and full flags after it. A write, flush or unknown
// operation gives one result beat. A read of n bytes (n = min(level, count,
// MAX_BURST)) gives n result beats, or one empty beat if n is zero, and
// blocks the input until its last byte has landed in the output queue; the
// single read port of the byte memory hands out one byte per cycle while
// the output queue has room, and its read data is registered. The byte
// memory is never cleared; a read only ever reaches entries a write filled.
// ============================================================================
`include "byte_ring_buffer_fifo_unit_assert.svh"

module byte_ring_buffer_fifo_unit #(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [brbf_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  brbf_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output brbf_pkg::t_out_item         o_out_item
);
    import brbf_pkg::*;

    // Pointer width, level width, and a compare width that holds both the
    // level and the capacity register.
    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > CAP_W) ? LW : CAP_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BURST = 1'b1;

    // Step a ring position, wrapping at the effective capacity.
    function automatic logic [PW-1:0] f_advance(input logic [PW-1:0] pos,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(pos) + CW'(1);
        return (nxt >= cap) ? '0 : nxt[PW-1:0];
    endfunction

    // Assemble one result beat around the level that follows it.
    function automatic t_out_item f_result(input logic [7:0]    data,
                                           input logic          has,
                                           input logic          lst,
                                           input logic          acc,
                                           input logic [LW-1:0] lvl,
                                           input logic [CW-1:0] cap);
        t_out_item     res;
        logic [CW-1:0] lvl_cw;
        lvl_cw         = CW'(lvl);
        res.data_out   = data;
        res.has_data   = has;
        res.last       = lst;
        res.accepted   = acc;
        res.fill_level = lvl_cw[FILL_W-1:0];
        res.empty_res  = (lvl_cw == '0);
        res.full_res   = (lvl_cw >= cap);
        return res;
    endfunction

    // Configuration register and the capacity it stands for.
    logic [CAP_W-1:0] r_capacity;
    logic [CW-1:0]    cap_eff;

    // Ring state.
    logic             r_state, n_state;
    logic [PW-1:0]    r_rd_pos, n_rd_pos;
    logic [PW-1:0]    r_wr_pos, n_wr_pos;
    logic [LW-1:0]    r_level, n_level;
    logic [CNT_W-1:0] r_remain, n_remain;
    logic [CW-1:0]    level_cw;

    // Byte memory with its registered read data and the tags that travel
    // with a read while it is in flight.
    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_mem_q;
    logic             r_rd_pend;
    logic             r_pend_last;
    logic [LW-1:0]    r_pend_level;

    // Two-entry output queue; entry 0 is the head shown on the port.
    t_out_item        r_oq [2];
    logic [1:0]       r_oq_cnt;
    logic [1:0]       oq_slot;
    logic [2:0]       occ;

    logic             pop;
    logic             can_go;
    logic             accept;
    logic             issue;
    logic             issue_last;
    logic             push;
    t_out_item        push_item;
    logic             mem_we;
    logic             write_ok;
    logic [CNT_W-1:0] sat_cnt;
    logic [CNT_W-1:0] rd_len;

    // ------------------------------------------------------------------------
    // Capacity: zero acts as one slot, anything beyond the memory as DEPTH.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CW'(1);
        end else if (CW'(r_capacity) > CW'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(r_capacity);
        end
    end

    // ------------------------------------------------------------------------
    // Handshake. A slot in the output queue is counted as taken as soon as
    // its read is issued, so a returning byte always finds room. New input
    // waits until the last byte of a burst has landed in the queue.
    // ------------------------------------------------------------------------
    assign pop        = o_out_valid && !i_out_stall;
    assign occ        = {1'b0, r_oq_cnt} + {2'b00, r_rd_pend};
    assign can_go     = (occ < 3'd2) || ((occ == 3'd2) && pop);
    assign o_in_stall = !((r_state == ST_IDLE) && !r_rd_pend && can_go);
    assign accept     = i_in_valid && !o_in_stall;

    assign level_cw = CW'(r_level);
    assign write_ok = (level_cw < cap_eff);
    assign sat_cnt  = (i_in_item.count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                             : i_in_item.count;
    assign rd_len   = (level_cw < CW'(sat_cnt)) ? level_cw[CNT_W-1:0] : sat_cnt;

    // ------------------------------------------------------------------------
    // Sequencer. Writes and status beats finish in the accept cycle; a read
    // issues one memory read per cycle, the first on accept, while the queue has room.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_rd_pos   = r_rd_pos;
        n_wr_pos   = r_wr_pos;
        n_level    = r_level;
        n_remain   = r_remain;
        issue      = 1'b0;
        issue_last = 1'b0;
        push       = 1'b0;
        mem_we     = 1'b0;
        push_item  = f_result(8'h00, 1'b0, 1'b1, 1'b0, r_level, cap_eff);

        // A byte read in the previous cycle lands in the queue now.
        if (r_rd_pend) begin
            push      = 1'b1;
            push_item = f_result(r_mem_q, 1'b1, r_pend_last, 1'b0, r_pend_level,
                                 cap_eff);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_item.operation)
                        OP_WRITE: begin
                            push = 1'b1;
                            if (write_ok) begin
                                mem_we   = 1'b1;
                                n_wr_pos = f_advance(r_wr_pos, cap_eff);
                                n_level  = r_level + LW'(1);
                            end
                            push_item = f_result(8'h00, 1'b0, 1'b1, write_ok, n_level,
                                                 cap_eff);
                        end
                        OP_READ: begin
                            if (rd_len == '0) begin
                                push = 1'b1;
                            end else begin
                                issue      = 1'b1;
                                issue_last = (rd_len == CNT_W'(1));
                                n_remain   = rd_len - CNT_W'(1);
                                if (!issue_last) begin
                                    n_state = ST_BURST;
                                end
                            end
                        end
                        OP_FLUSH: begin
                            push      = 1'b1;
                            n_level   = '0;
                            n_rd_pos  = '0;
                            n_wr_pos  = '0;
                            push_item = f_result(8'h00, 1'b0, 1'b1, 1'b0, '0, cap_eff);
                        end
                        default: begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            ST_BURST: begin
                if (can_go) begin
                    issue      = 1'b1;
                    issue_last = (r_remain == CNT_W'(1));
                    n_remain   = r_remain - CNT_W'(1);
                    if (issue_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (issue) begin
            n_rd_pos = f_advance(r_rd_pos, cap_eff);
            n_level  = r_level - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pos  <= '0;
            r_wr_pos  <= '0;
            r_level   <= '0;
            r_remain  <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pos  <= n_rd_pos;
            r_wr_pos  <= n_wr_pos;
            r_level   <= n_level;
            r_remain  <= n_remain;
            r_rd_pend <= issue;
        end
    end

    // Tags of the read in flight: its last flag and the level after it.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last  <= issue_last;
            r_pend_level <= n_level;
        end
    end

    // ------------------------------------------------------------------------
    // Byte memory: one write port, one read port with registered data. A
    // write and a read never fall in the same cycle, so no bypass is needed.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_pos] <= i_in_item.data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_mem_q <= r_mem[r_rd_pos];
        end
    end

    // ------------------------------------------------------------------------
    // Output queue. It decouples the ring from a stalled consumer. A beat
    // pushed in the cycle of a pop goes to the slot that the pop frees up.
    // ------------------------------------------------------------------------
    assign oq_slot = r_oq_cnt - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_cnt <= '0;
        end else begin
            r_oq_cnt <= r_oq_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (oq_slot == 2'd0)) begin
            r_oq[0] <= push_item;
        end else if (pop) begin
            r_oq[0] <= r_oq[1];
        end
        if (push && (oq_slot == 2'd1)) begin
            r_oq[1] <= push_item;
        end
    end

    assign o_out_valid = (r_oq_cnt != '0);
    assign o_out_item  = r_oq[0];

    // ------------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------------
    `BRBF_ASSERT(a_queue_room, occ <= 3'd2, "output queue overbooked")
    `BRBF_ASSERT(a_level_bound, level_cw <= CW'(DEPTH), "level beyond the memory size")
    `BRBF_ASSERT_NEXT(a_read_lands, r_rd_pend, o_out_valid, "returned byte not presented")

endmodule
